FILE: rtl/cau_pkg.sv
package cau_pkg;

  // Command codes on the request
  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSub = 3'd1;
  localparam logic [2:0] CmdMul = 3'd2;
  localparam logic [2:0] CmdDiv = 3'd3;

  // Magnitude order codes
  localparam logic [1:0] OrdEqual   = 2'd0;
  localparam logic [1:0] OrdLess    = 2'd1;
  localparam logic [1:0] OrdGreater = 2'd2;

  // Status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatSat     = 2'd1;
  localparam logic [1:0] StatDivZero = 2'd2;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    OpAdd,
    OpSub,
    OpMul,
    OpDiv,
    OpCmp
  } op_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               exact_equal;
    logic [1:0]         magnitude_order;
    logic [1:0]         status;
  } rsp_t;

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// Complex fixed-point ALU: add, subtract, multiply, divide or compare two complex operands
// (Q8.8 by default), one request per cycle unless the queue or the output stalls, results
// in request order. A request passes two front stages (operand capture, then the eight
// parallel products), a four-entry queue and a back pipeline of DATA_WIDTH + 5 stages, most
// of them the restoring divider that retires one quotient bit per stage. Every command
// reports exact equality and magnitude order; results saturate with status 1, and divide
// by a zero operand b gives zero with status 2.
module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cau_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cau_pkg::rsp_t out_rsp_o
);

  localparam int unsigned EntryW = 3 + 1 + 2 * (DATA_WIDTH + 1) + 16 * DATA_WIDTH;

  logic              push, full, pop, empty;
  logic [EntryW-1:0] push_data, pop_data;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .ENTRY_W    (EntryW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  cau_queue #(
    .WIDTH (EntryW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  cau_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ENTRY_W    (EntryW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: rtl/cau_front.sv
module cau_front #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned ENTRY_W    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cau_pkg::req_t       in_req_i,
  output logic                push_o,
  output logic [ENTRY_W-1:0]  push_data_o,
  input  logic                full_i
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH;

  typedef struct packed {
    cau_pkg::op_e         op;
    logic                 eq;
    logic signed [DW:0]   sum_re;
    logic signed [DW:0]   sum_im;
    logic signed [PW-1:0] rr;
    logic signed [PW-1:0] ii;
    logic signed [PW-1:0] ri;
    logic signed [PW-1:0] ir;
    logic signed [PW-1:0] aa;
    logic signed [PW-1:0] ai2;
    logic signed [PW-1:0] bb;
    logic signed [PW-1:0] bi2;
  } entry_t;

  logic                 v1_q, v2_q;
  logic                 adv1, adv2;
  cau_pkg::op_e         op_d, op_q;
  logic signed [DW-1:0] ar_d, ai_d, br_d, bi_d;
  logic signed [DW-1:0] ar_q, ai_q, br_q, bi_q;
  entry_t               ent_d, ent_q;

  // Stage handshake: F2 drains into the queue, F1 into F2
  assign push_o     = v2_q && !full_i;
  assign adv2       = !v2_q || push_o;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // Operand width conversion: low bits taken, extra high bits zero
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      ar_d[i] = (i < 16) ? in_req_i.a_re[i & 15] : 1'b0;
      ai_d[i] = (i < 16) ? in_req_i.a_im[i & 15] : 1'b0;
      br_d[i] = (i < 16) ? in_req_i.b_re[i & 15] : 1'b0;
      bi_d[i] = (i < 16) ? in_req_i.b_im[i & 15] : 1'b0;
    end
  end

  // Classify the command
  always_comb begin
    case (in_req_i.cmd)
      cau_pkg::CmdAdd: op_d = cau_pkg::OpAdd;
      cau_pkg::CmdSub: op_d = cau_pkg::OpSub;
      cau_pkg::CmdMul: op_d = cau_pkg::OpMul;
      cau_pkg::CmdDiv: op_d = cau_pkg::OpDiv;
      default:         op_d = cau_pkg::OpCmp;
    endcase
  end

  // Products, sums and equality for F2
  always_comb begin
    ent_d.op  = op_q;
    ent_d.eq  = (ar_q == br_q) && (ai_q == bi_q);
    if (op_q == cau_pkg::OpSub) begin
      ent_d.sum_re = (DW+1)'(ar_q) - (DW+1)'(br_q);
      ent_d.sum_im = (DW+1)'(ai_q) - (DW+1)'(bi_q);
    end else begin
      ent_d.sum_re = (DW+1)'(ar_q) + (DW+1)'(br_q);
      ent_d.sum_im = (DW+1)'(ai_q) + (DW+1)'(bi_q);
    end
    ent_d.rr  = ar_q * br_q;
    ent_d.ii  = ai_q * bi_q;
    ent_d.ri  = ar_q * bi_q;
    ent_d.ir  = ai_q * br_q;
    ent_d.aa  = ar_q * ar_q;
    ent_d.ai2 = ai_q * ai_q;
    ent_d.bb  = br_q * br_q;
    ent_d.bi2 = bi_q * bi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      op_q <= op_d;
      ar_q <= ar_d;
      ai_q <= ai_d;
      br_q <= br_d;
      bi_q <= bi_d;
    end
    if (adv2 && v1_q) ent_q <= ent_d;
  end

  assign push_data_o = ENTRY_W'(ent_q);

endmodule

FILE: rtl/cau_queue.sv
module cau_queue #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Queue bookkeeping checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[PtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/cau_back.sv
module cau_back #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned ENTRY_W    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                pop_o,
  input  logic [ENTRY_W-1:0]  pop_data_i,
  input  logic                empty_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cau_pkg::rsp_t       out_rsp_o
);

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned PW  = 2 * DATA_WIDTH;
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned RW  = 3 * DATA_WIDTH + FRAC_BITS + 2;
  localparam int unsigned NST = DATA_WIDTH + 2;

  typedef struct packed {
    cau_pkg::op_e         op;
    logic                 eq;
    logic signed [DW:0]   sum_re;
    logic signed [DW:0]   sum_im;
    logic signed [PW-1:0] rr;
    logic signed [PW-1:0] ii;
    logic signed [PW-1:0] ri;
    logic signed [PW-1:0] ir;
    logic signed [PW-1:0] aa;
    logic signed [PW-1:0] ai2;
    logic signed [PW-1:0] bb;
    logic signed [PW-1:0] bi2;
  } entry_t;

  typedef struct packed {
    cau_pkg::op_e         op;
    logic                 eq;
    logic [1:0]           ord;
    logic                 dz;
    logic signed [DW:0]   sum_re;
    logic signed [DW:0]   sum_im;
    logic signed [SW-1:0] mulx;
    logic signed [SW-1:0] muly;
    logic signed [SW-1:0] divx;
    logic signed [SW-1:0] divy;
    logic [PW-1:0]        den;
  } b1_t;

  typedef struct packed {
    logic                 isdiv;
    logic                 dz;
    logic                 eq;
    logic [1:0]           ord;
    logic signed [DW-1:0] bre;
    logic signed [DW-1:0] bim;
    logic                 bflag;
    logic                 neg_x;
    logic                 neg_y;
    logic                 big_x;
    logic                 big_y;
    logic [RW-1:0]        rem_x;
    logic [RW-1:0]        rem_y;
    logic [DW:0]          q_x;
    logic [DW:0]          q_y;
    logic [PW-1:0]        den;
  } pipe_t;

  typedef struct packed {
    logic                 flag;
    logic signed [DW-1:0] val;
  } sat_t;

  localparam logic signed [SW-1:0] MaxV = SW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [SW-1:0] MinV = -MaxV - SW'(1);
  localparam logic [DW:0]          Half = (DW+1)'(1) << (DW-1);

  // Clamp a wide signed value to the data range
  function automatic sat_t sat_fn(input logic signed [SW-1:0] v);
    sat_t r;
    if (v > MaxV) begin
      r.flag = 1'b1;
      r.val  = MaxV[DW-1:0];
    end else if (v < MinV) begin
      r.flag = 1'b1;
      r.val  = MinV[DW-1:0];
    end else begin
      r.flag = 1'b0;
      r.val  = v[DW-1:0];
    end
    return r;
  endfunction

  // Clamp a sign-magnitude quotient
  function automatic sat_t qsat_fn(input logic big, input logic neg, input logic [DW:0] q);
    sat_t r;
    if (neg) begin
      if (big || q > Half) begin
        r.flag = 1'b1;
        r.val  = MinV[DW-1:0];
      end else begin
        r.flag = 1'b0;
        r.val  = DW'((~q) + 1'b1);
      end
    end else begin
      if (big || q > Half - 1'b1) begin
        r.flag = 1'b1;
        r.val  = MaxV[DW-1:0];
      end else begin
        r.flag = 1'b0;
        r.val  = q[DW-1:0];
      end
    end
    return r;
  endfunction

  logic              en;
  entry_t            ent;
  b1_t               b1_d, b1_q;
  logic              b1_v_q;
  pipe_t             st_d [NST+1];
  pipe_t             st_q [NST+1];
  logic [NST:0]      v_q;
  logic              out_v_q;
  cau_pkg::rsp_t     out_d, out_q;
  logic [PW-1:0]     ma;

  // The whole back pipeline moves when the output slot frees up
  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en && !empty_i;
  assign ent   = entry_t'(pop_data_i);

  // B1: combine products, magnitudes and order
  always_comb begin
    ma          = $unsigned(ent.aa) + $unsigned(ent.ai2);
    b1_d.den    = $unsigned(ent.bb) + $unsigned(ent.bi2);
    b1_d.op     = ent.op;
    b1_d.eq     = ent.eq;
    b1_d.dz     = (b1_d.den == '0);
    if (ma == b1_d.den)    b1_d.ord = cau_pkg::OrdEqual;
    else if (ma < b1_d.den) b1_d.ord = cau_pkg::OrdLess;
    else                   b1_d.ord = cau_pkg::OrdGreater;
    b1_d.sum_re = ent.sum_re;
    b1_d.sum_im = ent.sum_im;
    b1_d.mulx   = SW'(ent.rr) - SW'(ent.ii);
    b1_d.muly   = SW'(ent.ri) + SW'(ent.ir);
    b1_d.divx   = SW'(ent.rr) + SW'(ent.ii);
    b1_d.divy   = SW'(ent.ir) - SW'(ent.ri);
  end

  // B2: non-divide results and divider setup
  always_comb begin
    sat_t sr, si;
    logic signed [SW-1:0] ax, ay;
    case (b1_q.op)
      cau_pkg::OpAdd, cau_pkg::OpSub: begin
        sr = sat_fn(SW'(b1_q.sum_re));
        si = sat_fn(SW'(b1_q.sum_im));
      end
      cau_pkg::OpMul: begin
        sr = sat_fn(b1_q.mulx >>> FRAC_BITS);
        si = sat_fn(b1_q.muly >>> FRAC_BITS);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    ax = b1_q.divx[SW-1] ? -b1_q.divx : b1_q.divx;
    ay = b1_q.divy[SW-1] ? -b1_q.divy : b1_q.divy;
    st_d[0].isdiv = (b1_q.op == cau_pkg::OpDiv);
    st_d[0].dz    = b1_q.dz;
    st_d[0].eq    = b1_q.eq;
    st_d[0].ord   = b1_q.ord;
    st_d[0].bre   = sr.val;
    st_d[0].bim   = si.val;
    st_d[0].bflag = sr.flag || si.flag;
    st_d[0].neg_x = b1_q.divx[SW-1];
    st_d[0].neg_y = b1_q.divy[SW-1];
    st_d[0].big_x = 1'b0;
    st_d[0].big_y = 1'b0;
    st_d[0].rem_x = RW'($unsigned(ax)) << FRAC_BITS;
    st_d[0].rem_y = RW'($unsigned(ay)) << FRAC_BITS;
    st_d[0].q_x   = '0;
    st_d[0].q_y   = '0;
    st_d[0].den   = b1_q.den;
  end

  // Divider: overflow check, then one quotient bit per stage
  for (genvar j = 1; j <= NST; j++) begin : g_div
    logic [RW-1:0] dsh;
    if (j == 1) begin : g_big
      assign dsh = RW'(st_q[0].den) << (DW + 1);
      always_comb begin
        st_d[1]       = st_q[0];
        st_d[1].big_x = (st_q[0].rem_x >= dsh);
        st_d[1].big_y = (st_q[0].rem_y >= dsh);
      end
    end else begin : g_bit
      localparam int unsigned K = NST - j;
      assign dsh = RW'(st_q[j-1].den) << K;
      always_comb begin
        st_d[j] = st_q[j-1];
        if (st_q[j-1].rem_x >= dsh) begin
          st_d[j].rem_x = st_q[j-1].rem_x - dsh;
          st_d[j].q_x[K] = 1'b1;
        end
        if (st_q[j-1].rem_y >= dsh) begin
          st_d[j].rem_y = st_q[j-1].rem_y - dsh;
          st_d[j].q_y[K] = 1'b1;
        end
      end
    end
  end

  // Final selection into the output register
  always_comb begin
    sat_t qx, qy;
    logic signed [DW-1:0] rre, rim;
    logic [1:0] stat;
    qx = qsat_fn(st_q[NST].big_x, st_q[NST].neg_x, st_q[NST].q_x);
    qy = qsat_fn(st_q[NST].big_y, st_q[NST].neg_y, st_q[NST].q_y);
    if (!st_q[NST].isdiv) begin
      rre  = st_q[NST].bre;
      rim  = st_q[NST].bim;
      stat = st_q[NST].bflag ? cau_pkg::StatSat : cau_pkg::StatOk;
    end else if (st_q[NST].dz) begin
      rre  = '0;
      rim  = '0;
      stat = cau_pkg::StatDivZero;
    end else begin
      rre  = qx.val;
      rim  = qy.val;
      stat = (qx.flag || qy.flag) ? cau_pkg::StatSat : cau_pkg::StatOk;
    end
    for (int i = 0; i < 16; i++) begin
      out_d.res_re[i] = (i < DW) ? rre[i % DW] : 1'b0;
      out_d.res_im[i] = (i < DW) ? rim[i % DW] : 1'b0;
    end
    out_d.exact_equal     = st_q[NST].eq;
    out_d.magnitude_order = st_q[NST].ord;
    out_d.status          = stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q  <= pop_o;
      v_q     <= {v_q[NST-1:0], b1_v_q};
      out_v_q <= v_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q  <= b1_d;
      out_q <= out_d;
      for (int j = 0; j <= NST; j++) st_q[j] <= st_d[j];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: dv/cau_checker.sv
`timescale 1ns / 1ps

module cau_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cau_pkg::req_t  in_req_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cau_pkg::rsp_t  out_rsp_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import cau_pkg::*;

  localparam longint MaxVal = 32767;
  localparam longint MinVal = -32768;

  rsp_t expected_q[$];

  // Clamp a wide value to 16 bits, flag when clamped
  function automatic logic [15:0] clamp16(input longint v, inout logic sat);
    if (v > MaxVal) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (v < MinVal) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // Fixed-point quotient truncated toward zero
  function automatic longint quot_trunc(input longint num, input longint den);
    longint mag;
    mag = ((num < 0) ? -num : num) * 256 / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic rsp_t compute_result(input req_t r);
    rsp_t   o;
    longint ar, ai, br, bi, ma, mb, xr, xi;
    logic   sat;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    ma = ar * ar + ai * ai;
    mb = br * br + bi * bi;
    sat = 1'b0;
    o = '0;
    case (r.cmd)
      CmdAdd, CmdSub: begin
        xr = (r.cmd == CmdAdd) ? ar + br : ar - br;
        xi = (r.cmd == CmdAdd) ? ai + bi : ai - bi;
        o.res_re = clamp16(xr, sat);
        o.res_im = clamp16(xi, sat);
      end
      CmdMul: begin
        // >>> on longint floors toward minus infinity
        xr = (ar * br - ai * bi) >>> 8;
        xi = (ar * bi + ai * br) >>> 8;
        o.res_re = clamp16(xr, sat);
        o.res_im = clamp16(xi, sat);
      end
      CmdDiv: begin
        if (mb == 0) begin
          o.status = StatDivZero;
        end else begin
          o.res_re = clamp16(quot_trunc(ar * br + ai * bi, mb), sat);
          o.res_im = clamp16(quot_trunc(ai * br - ar * bi, mb), sat);
        end
      end
      default: ;
    endcase
    if (o.status == StatOk && sat) o.status = StatSat;
    o.exact_equal = (ar == br) && (ai == bi);
    o.magnitude_order = (ma == mb) ? OrdEqual : ((ma < mb) ? OrdLess : OrdGreater);
    return o;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(compute_result(in_req_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %p", out_rsp_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (exp_rsp !== out_rsp_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %p actual %p", exp_rsp, out_rsp_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int NumRandom = 1100;
  localparam int IdleLimit = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  req_t        in_req;
  logic        out_valid;
  logic        out_ready;
  rsp_t        out_rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  logic        stall_mode = 1'b0;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  complex_arithmetic_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp)
  );

  cau_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_rsp_i(out_rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: alternates between stall-free stretches and a random stall pattern
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_complex_arithmetic_unit NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input req_t r);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_random();
    req_t r;
    r.cmd  = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 4));
    r.a_re = pick_value();
    r.a_im = pick_value();
    if ($urandom_range(0, 9) == 0) begin
      r.b_re = r.a_re;
      r.b_im = r.a_im;
    end else if ($urandom_range(0, 9) == 0) begin
      // swapped parts: equal magnitude, equal only when the parts match
      r.b_re = r.a_im;
      r.b_im = r.a_re;
    end else if (r.cmd == CmdDiv && $urandom_range(0, 7) == 0) begin
      r.b_re = '0;
      r.b_im = '0;
    end else begin
      r.b_re = pick_value();
      r.b_im = pick_value();
    end
    send_request(r);
  endtask

  initial begin
    req_t r;
    int   sent;
    int   burst;
    in_valid    = 1'b0;
    in_req      = '0;
    out_ready   = 1'b0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command at the operand extremes, divide by zero, spare codes
    for (int c = 0; c < 8; c++) begin
      r.cmd = 3'(c);
      r.a_re = 16'h7fff; r.a_im = 16'h8000; r.b_re = 16'h8000; r.b_im = 16'h7fff;
      send_request(r);
      r.a_re = 16'h8000; r.a_im = 16'h8000; r.b_re = 16'h8000; r.b_im = 16'h8000;
      send_request(r);
    end
    r = '{cmd: CmdDiv, a_re: 16'h0100, a_im: 16'h0200, b_re: 16'h0, b_im: 16'h0};
    send_request(r);
    r = '{cmd: CmdDiv, a_re: 16'h7fff, a_im: 16'h7fff, b_re: 16'h0001, b_im: 16'h0};
    send_request(r);
    r = '{cmd: CmdMul, a_re: 16'hffff, a_im: 16'h0, b_re: 16'h0001, b_im: 16'h0};
    send_request(r);
    r = '{cmd: CmdDiv, a_re: 16'hff00, a_im: 16'h0, b_re: 16'h0300, b_im: 16'h0};
    send_request(r);
    r = '{cmd: CmdAdd, a_re: 16'h0, a_im: 16'hffff, b_re: 16'h0, b_im: 16'h0001};
    send_request(r);

    // Random bursts with gaps
    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) send_random();
      sent += burst;
      if ($urandom_range(0, 3) != 0) send_idle($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    // Drain, then a short tail for stray results
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_complex_arithmetic_unit OK");
    end else begin
      $display("tb_complex_arithmetic_unit NOT OK");
    end
    $finish;
  end

endmodule
